/* src/rbt_pkg.sv */
package rbt_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO_KEY = 3'd4;
    localparam logic [2:0] ST_HELD     = 3'd5;
    localparam logic [2:0] ST_FREED    = 3'd6;

    // Slot index width carried along the chain (covers up to 256 slots)
    localparam int IDX_MAX_W = 8;
    localparam logic [7:0] REFS_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic        held_flag;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [7:0] refs;
        logic [4:0] live_entries;
    } out_t;

    // Running search summary handed from cell to cell
    typedef struct packed {
        logic                 hit_found;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic [7:0]           hit_refs;
        logic                 free_found;
        logic [IDX_MAX_W-1:0] free_idx;
    } chain_t;

    // Write-back controls broadcast to all cells
    typedef struct packed {
        logic inc;
        logic release_ref;
        logic insert;
    } ctrl_t;

endpackage

/* src/rbt_cell.sv */
module rbt_cell #(
    parameter int KEY_BITS   = 32,
    parameter int CELL_INDEX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  eval,
    input  logic [KEY_BITS-1:0]   key_in,
    input  rbt_pkg::chain_t       chain_in,
    output rbt_pkg::chain_t       chain_out,
    input  rbt_pkg::ctrl_t        ctrl,
    input  logic [KEY_BITS-1:0]   wr_key
);
    import rbt_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [7:0]          refs_reg;
    logic                valid_reg;
    logic                match_reg;
    logic                first_free_reg;

    logic match;
    logic first_free;
    logic [IDX_MAX_W-1:0] my_idx;

    assign my_idx = IDX_MAX_W'(CELL_INDEX);

    // Compare against the broadcast key and extend the chain summary
    always_comb
    begin
        match      = valid_reg && (key_reg == key_in);
        first_free = !valid_reg && !chain_in.free_found;
        chain_out  = chain_in;
        if (!chain_in.hit_found && match)
        begin
            chain_out.hit_found = 1'b1;
            chain_out.hit_idx   = my_idx;
            chain_out.hit_refs  = refs_reg;
        end
        if (first_free)
        begin
            chain_out.free_found = 1'b1;
            chain_out.free_idx   = my_idx;
        end
    end

    // Control state: valid bit and search marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            match_reg      <= 1'b0;
            first_free_reg <= 1'b0;
        end
        else
        begin
            if (eval)
            begin
                match_reg      <= match;
                first_free_reg <= first_free;
            end
            if (ctrl.insert && first_free_reg)
                valid_reg <= 1'b1;
            else if (ctrl.release_ref && match_reg && refs_reg <= 8'd1)
                valid_reg <= 1'b0;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && first_free_reg)
        begin
            key_reg  <= wr_key;
            refs_reg <= 8'd1;
        end
        else if (ctrl.inc && match_reg)
        begin
            if (refs_reg != REFS_MAX)
                refs_reg <= refs_reg + 8'd1;
        end
        else if (ctrl.release_ref && match_reg)
        begin
            if (refs_reg != 8'd0)
                refs_reg <= refs_reg - 8'd1;
        end
    end

endmodule

/* src/refcounted_block_table.sv */
// Reference-counted key table. Pulse start with an item while busy is low;
// the item is taken at that edge, busy is high for the following cycle, and
// the result appears on result with done high for exactly one cycle right
// after busy drops. The receiver cannot stall, so capture result whenever
// done is high. When an item is taken, the key compare in every slot cell
// and the lowest-hit / lowest-free search rippled along the cell chain are
// registered; the write state then writes the chosen cell back. A new item
// may be started in the same cycle its predecessor's done is high. Valid
// marks clear at reset; there is no clearing pass.
module refcounted_block_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rbt_pkg::in_t   request,
    output logic           done,
    output rbt_pkg::out_t  result
);
    import rbt_pkg::*;

    localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_WRITE
    } state_t;

    state_t state_reg;

    logic [1:0]           op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic                 held_reg;
    logic                 hit_found_reg;
    logic [IDX_MAX_W-1:0] hit_idx_reg;
    logic [7:0]           hit_refs_reg;
    logic                 free_found_reg;
    logic [IDX_MAX_W-1:0] free_idx_reg;
    logic [LIVE_W-1:0]    live_reg;
    logic [LIVE_W-1:0]    live_next;
    out_t                 result_reg;
    out_t                 result_next;
    logic                 done_reg;

    logic                 accept;
    logic [63:0]          key_wide;
    logic [KEY_BITS-1:0]  key_in;
    chain_t               chain [0:TABLE_ENTRIES];
    ctrl_t                ctrl;
    logic [IDX_MAX_W-1:0] slot_sel;
    logic [7:0]           refs_dec;
    logic [31:0]          live_ext;

    assign accept   = start && !busy;
    assign busy     = (state_reg == S_WRITE);
    assign done     = done_reg;
    assign result   = result_reg;
    assign key_wide = 64'(request.key);
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign chain[0] = '0;

    // Row of slot cells
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            rbt_cell #(
                .KEY_BITS   (KEY_BITS),
                .CELL_INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .eval      (accept),
                .key_in    (key_in),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1]),
                .ctrl      (ctrl),
                .wr_key    (key_reg)
            );
        end
    endgenerate

    // Write-back decision and result
    always_comb
    begin
        ctrl        = '0;
        live_next   = live_reg;
        slot_sel    = '0;
        refs_dec    = (hit_refs_reg != 8'd0) ? hit_refs_reg - 8'd1 : 8'd0;
        result_next = '0;
        result_next.status = ST_MISS;
        if (key_reg == '0)
            result_next.status = ST_ZERO_KEY;
        else
        begin
            case (op_reg)
                OP_ADD:
                begin
                    if (held_reg)
                        result_next.status = ST_HELD;
                    else if (hit_found_reg)
                    begin
                        ctrl.inc           = 1'b1;
                        result_next.status = ST_HIT;
                        slot_sel           = hit_idx_reg;
                        result_next.refs   = (hit_refs_reg != REFS_MAX) ?
                                             hit_refs_reg + 8'd1 : REFS_MAX;
                    end
                    else if (free_found_reg)
                    begin
                        ctrl.insert        = 1'b1;
                        live_next          = live_reg + LIVE_W'(1);
                        result_next.status = ST_INSERTED;
                        slot_sel           = free_idx_reg;
                        result_next.refs   = 8'd1;
                    end
                    else
                        result_next.status = ST_FULL;
                end
                OP_RELEASE:
                begin
                    if (hit_found_reg)
                    begin
                        ctrl.release_ref = 1'b1;
                        slot_sel         = hit_idx_reg;
                        result_next.refs = refs_dec;
                        if (refs_dec == 8'd0)
                        begin
                            result_next.status = ST_FREED;
                            if (live_reg != '0)
                                live_next = live_reg - LIVE_W'(1);
                        end
                        else
                            result_next.status = ST_HIT;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit_found_reg)
                    begin
                        ctrl.inc           = 1'b1;
                        result_next.status = ST_HIT;
                        slot_sel           = hit_idx_reg;
                        result_next.refs   = (hit_refs_reg != REFS_MAX) ?
                                             hit_refs_reg + 8'd1 : REFS_MAX;
                    end
                end
                default:
                begin
                    result_next.status = ST_MISS;
                end
            endcase
        end
        if (state_reg != S_WRITE)
        begin
            ctrl      = '0;
            live_next = live_reg;
        end
        live_ext                 = 32'(live_next);
        result_next.slot         = slot_sel[3:0];
        result_next.live_entries = live_ext[4:0];
    end

    // Sequencer, live count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    live_reg  <= live_next;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Captured item, search summary and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= request.operation;
            key_reg        <= key_in;
            held_reg       <= request.held_flag;
            hit_found_reg  <= chain[TABLE_ENTRIES].hit_found;
            hit_idx_reg    <= chain[TABLE_ENTRIES].hit_idx;
            hit_refs_reg   <= chain[TABLE_ENTRIES].hit_refs;
            free_found_reg <= chain[TABLE_ENTRIES].free_found;
            free_idx_reg   <= chain[TABLE_ENTRIES].free_idx;
        end
        if (state_reg == S_WRITE)
            result_reg <= result_next;
    end

    // Checks
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result strobe missing after write cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not enter write cycle");

    a_insert_refs: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_INSERTED |-> result.refs == 8'd1)
        else $error("inserted entry with count other than one");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= TABLE_ENTRIES)
        else $error("live count exceeds table size");

endmodule

/* bench/tb_refcounted_block_table.sv */
module tb_refcounted_block_table;

    timeunit 1ns;
    timeprecision 1ps;

    import rbt_pkg::*;

    localparam int          SLOTS       = 16;
    localparam int          POOL_SIZE   = 24;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic clk;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    in_t  request = '0;
    logic busy;
    logic done;
    out_t result;

    // Shadow copy of the table
    logic [31:0] shadow_keys  [SLOTS];
    logic [7:0]  shadow_refs  [SLOTS];
    logic        shadow_valid [SLOTS];
    int unsigned shadow_live;

    out_t        expected_results [$];
    out_t        oldest_result;
    int unsigned idle_pct    = 0;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;

    refcounted_block_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one item to the shadow table, return the response it should give
    function automatic out_t table_apply(input in_t req);
        out_t rsp;
        int   hit_idx;
        int   free_idx;
        rsp      = '0;
        hit_idx  = -1;
        free_idx = -1;
        rsp.status = ST_MISS;
        // scan from the top so the lowest match / free slot wins
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_keys[i] == req.key)
                hit_idx = i;
            if (!shadow_valid[i])
                free_idx = i;
        end
        if (req.key == '0)
            rsp.status = ST_ZERO_KEY;
        else
        begin
            case (req.operation)
                OP_ADD:
                begin
                    if (req.held_flag)
                        rsp.status = ST_HELD;
                    else if (hit_idx >= 0)
                    begin
                        if (shadow_refs[hit_idx] < REFS_MAX)
                            shadow_refs[hit_idx]++;
                        rsp.status = ST_HIT;
                        rsp.slot   = 4'(hit_idx);
                        rsp.refs   = shadow_refs[hit_idx];
                    end
                    else if (free_idx >= 0)
                    begin
                        shadow_keys[free_idx]  = req.key;
                        shadow_refs[free_idx]  = 8'd1;
                        shadow_valid[free_idx] = 1'b1;
                        shadow_live++;
                        rsp.status = ST_INSERTED;
                        rsp.slot   = 4'(free_idx);
                        rsp.refs   = 8'd1;
                    end
                    else
                        rsp.status = ST_FULL;
                end
                OP_RELEASE:
                begin
                    if (hit_idx >= 0)
                    begin
                        if (shadow_refs[hit_idx] > 0)
                            shadow_refs[hit_idx]--;
                        rsp.slot = 4'(hit_idx);
                        rsp.refs = shadow_refs[hit_idx];
                        if (shadow_refs[hit_idx] == 0)
                        begin
                            shadow_valid[hit_idx] = 1'b0;
                            if (shadow_live > 0)
                                shadow_live--;
                            rsp.status = ST_FREED;
                        end
                        else
                            rsp.status = ST_HIT;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit_idx >= 0)
                    begin
                        if (shadow_refs[hit_idx] < REFS_MAX)
                            shadow_refs[hit_idx]++;
                        rsp.status = ST_HIT;
                        rsp.slot   = 4'(hit_idx);
                        rsp.refs   = shadow_refs[hit_idx];
                    end
                end
                default: ;
            endcase
        end
        rsp.live_entries = 5'(shadow_live);
        return rsp;
    endfunction

    // Hand one item to the block, record its response, then maybe idle
    task automatic issue_request(input in_t req);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(table_apply(req));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [31:0] key,
                           input logic held);
        in_t req;
        req.operation = op;
        req.key       = key;
        req.held_flag = held;
        issue_request(req);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Response checker: the block cannot be stalled, so take every done
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("response with no item outstanding");
                errors++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("status", 32'(oldest_result.status),
                            32'(result.status));
                check_field("slot", 32'(oldest_result.slot), 32'(result.slot));
                check_field("refs", 32'(oldest_result.refs), 32'(result.refs));
                check_field("live_entries", 32'(oldest_result.live_entries),
                            32'(result.live_entries));
            end
        end
    end

    // Every operation, key extremes, zero key, held add, misses, unused op
    task automatic test_basic_ops();
        send_op(OP_ADD, 32'h0, 1'b0);
        send_op(OP_RELEASE, 32'h0, 1'b1);
        send_op(OP_LOOKUP, 32'h0, 1'b0);
        send_op(OP_UNUSED, 32'h0, 1'b1);
        send_op(OP_RELEASE, 32'hFFFF_FFFF, 1'b0);   // release on empty table
        send_op(OP_LOOKUP, 32'h0000_0001, 1'b0);    // lookup miss
        send_op(OP_ADD, 32'hFFFF_FFFF, 1'b0);
        send_op(OP_ADD, 32'h0000_0001, 1'b0);
        send_op(OP_ADD, 32'hFFFF_FFFF, 1'b0);       // add hit
        send_op(OP_ADD, 32'h0000_0001, 1'b1);       // held add
        send_op(OP_ADD, 32'h7FFF_FFFF, 1'b1);       // held add of a new key
        send_op(OP_LOOKUP, 32'h0000_0001, 1'b1);
        send_op(OP_UNUSED, 32'h0000_0001, 1'b0);
        send_op(OP_RELEASE, 32'hFFFF_FFFF, 1'b1);
        send_op(OP_RELEASE, 32'hFFFF_FFFF, 1'b0);   // frees slot 0
        send_op(OP_ADD, 32'h8000_0000, 1'b0);       // reuses lowest free slot
        send_op(OP_RELEASE, 32'h7FFF_FFFF, 1'b0);
        send_op(OP_RELEASE, 32'h0000_0001, 1'b0);
        send_op(OP_RELEASE, 32'h0000_0001, 1'b0);
        send_op(OP_RELEASE, 32'h8000_0000, 1'b0);
    endtask

    // Fill every slot, overflow, then drain
    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            send_op(OP_ADD, 32'h1000_0000 + 32'(i), 1'b0);
        send_op(OP_ADD, 32'hDEAD_0001, 1'b0);       // no free slot
        send_op(OP_LOOKUP, 32'h1000_0005, 1'b0);
        send_op(OP_RELEASE, 32'h1000_0005, 1'b0);
        for (int i = 0; i < SLOTS; i++)
            send_op(OP_RELEASE, 32'h1000_0000 + 32'(i), 1'b0);
    endtask

    // Drive one count into saturation at 255, then release it down to free
    task automatic test_count_saturation();
        send_op(OP_ADD, 32'h0000_5A5A, 1'b0);
        for (int i = 0; i < 257; i++)
            send_op(OP_LOOKUP, 32'h0000_5A5A, 1'($urandom_range(1)));
        send_op(OP_ADD, 32'h0000_5A5A, 1'b0);
        for (int i = 0; i < 255; i++)
            send_op(OP_RELEASE, 32'h0000_5A5A, 1'b0);
    endtask

    // Random traffic over a small key pool so hits, fills and frees happen
    task automatic test_random_traffic(input int unsigned count);
        logic [31:0] key_pool [POOL_SIZE];
        in_t         req;
        int unsigned sel;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0)
                key_pool[i] = 32'h1;
        end
        for (int unsigned n = 0; n < count; n++)
        begin
            sel           = $urandom_range(99);
            req.key       = key_pool[$urandom_range(POOL_SIZE - 1)];
            req.held_flag = ($urandom_range(9) == 0);
            if (sel < 40)
                req.operation = OP_ADD;
            else if (sel < 70)
                req.operation = OP_RELEASE;
            else if (sel < 92)
                req.operation = OP_LOOKUP;
            else if (sel < 95)
            begin
                req.operation = OP_UNUSED;
                req.held_flag = 1'($urandom_range(1));
            end
            else
            begin
                // noise: any op, zero or stray key
                req.operation = 2'($urandom_range(3));
                req.key       = $urandom_range(1) ? 32'h0 : 32'($urandom);
                req.held_flag = 1'($urandom_range(1));
            end
            issue_request(req);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_keys[i]  = '0;
            shadow_refs[i]  = '0;
            shadow_valid[i] = 1'b0;
        end
        shadow_live = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 23;
        test_basic_ops();
        test_table_full();
        idle_pct = 0;
        test_count_saturation();

        // idle phases: none, sender 80%, none, mixed 23%
        idle_pct = 0;
        test_random_traffic(50);
        idle_pct = 80;
        test_random_traffic(45);
        idle_pct = 0;
        test_random_traffic(45);
        idle_pct = 23;
        test_random_traffic(45);

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/rbt_pkg.sv
src/rbt_cell.sv
src/refcounted_block_table.sv
bench/tb_refcounted_block_table.sv
